// ===== hdl/gtba_pkg.sv =====
// Shared types and constants for the gated three-axis bias averager.
// Used by the top level and the bit-serial divider; depends on nothing.
`default_nettype none

package gtba_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int SUM_BITS    = 32;
    localparam int COUNT_BITS  = 16;
    localparam int MEAN_BITS   = 16;
    localparam int GATE_BITS   = 16;
    localparam int MAG_BITS    = SAMPLE_BITS + 1;
    localparam int STEP_BITS   = $clog2(SUM_BITS);

    localparam logic [COUNT_BITS-1:0] MAX_SAMPLES = COUNT_BITS'(65535);
    localparam logic [GATE_BITS-1:0]  GATE_RESET  = GATE_BITS'(32768);

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef logic signed [SUM_BITS-1:0]  sum_t;
    typedef logic        [COUNT_BITS-1:0] count_t;
    typedef logic signed [MEAN_BITS-1:0] mean_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_DONE
    } state_t;

    // Control from the sequencer to the three dividers.
    typedef struct packed {
        logic load;
        logic step;
    } div_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/gtba_div.sv =====
// Restoring bit-serial divider: one quotient bit per step, with sign and saturation.
// Depends on gtba_pkg for widths and the control struct.
`default_nettype none

module gtba_div
    import gtba_pkg::*;
(
    input  wire logic     clk,
    input  wire div_ctl_t ctl,
    input  wire sum_t     sum,
    input  wire count_t   count,
    output mean_t         mean
);

    localparam logic [SUM_BITS-1:0] POS_LIMIT = SUM_BITS'((2 ** (MEAN_BITS - 1)) - 1);
    localparam logic [SUM_BITS-1:0] NEG_LIMIT = SUM_BITS'(2 ** (MEAN_BITS - 1));

    // The dividend register shifts out the magnitude and shifts in quotient bits.
    logic [SUM_BITS-1:0]   dvd_reg, dvd_next;
    logic [COUNT_BITS-1:0] rem_reg, rem_next;
    logic                  neg_reg, neg_next;
    logic [COUNT_BITS:0]   trial;
    logic [COUNT_BITS:0]   diff;

    always_comb
    begin
        trial    = {rem_reg, dvd_reg[SUM_BITS-1]};
        diff     = trial - {1'b0, count};
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        neg_next = neg_reg;
        if (ctl.load)
        begin
            neg_next = sum[SUM_BITS-1];
            dvd_next = sum[SUM_BITS-1] ? (~sum + SUM_BITS'(1)) : sum;
            rem_next = '0;
        end
        else if (ctl.step)
        begin
            if (trial >= {1'b0, count})
            begin
                rem_next = diff[COUNT_BITS-1:0];
                dvd_next = {dvd_reg[SUM_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[COUNT_BITS-1:0];
                dvd_next = {dvd_reg[SUM_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    // An empty accumulator reads as zero; otherwise apply sign and clamp.
    always_comb
    begin
        if (count == '0)
            mean = '0;
        else if (neg_reg)
        begin
            if (dvd_reg > NEG_LIMIT)
                mean = mean_t'(NEG_LIMIT[MEAN_BITS-1:0]);
            else
                mean = mean_t'(~dvd_reg[MEAN_BITS-1:0] + MEAN_BITS'(1));
        end
        else
        begin
            if (dvd_reg > POS_LIMIT)
                mean = mean_t'(POS_LIMIT[MEAN_BITS-1:0]);
            else
                mean = mean_t'(dvd_reg[MEAN_BITS-1:0]);
        end
    end

endmodule

`default_nettype wire

// ===== hdl/gated_three_axis_bias_averager.sv =====
// Gated three-axis bias averager: stillness gate, running sums and bit-serial means.
// An input item is accepted only while idle; the block then runs load, the 32-step
// restoring divider loop and the output hand-off before it is ready again; a stalled
// consumer holds the block in its last state.
// Reset (rst_n, asynchronous, active low) zeroes the sums and count, sets the gate
// to 32768 and leaves the block idle and ready. Depends on gtba_pkg and gtba_div.
`default_nettype none

module gated_three_axis_bias_averager
    import gtba_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,

    // Configuration: the stillness gate register.
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [GATE_BITS-1:0]        cfg_data,

    // Input items.
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        command,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_x,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_y,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_z,

    // Result items.
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             accepted,
    output logic [COUNT_BITS-1:0]            sample_total,
    output logic signed [MEAN_BITS-1:0]      mean_x,
    output logic signed [MEAN_BITS-1:0]      mean_y,
    output logic signed [MEAN_BITS-1:0]      mean_z
);

    // Magnitude of a sample, one bit wider so the most negative value is exact.
    function automatic logic [MAG_BITS-1:0] magnitude(input logic [SAMPLE_BITS-1:0] v);
        logic [MAG_BITS-1:0] ext;
        begin
            ext = {v[SAMPLE_BITS-1], v};
            magnitude = v[SAMPLE_BITS-1] ? (~ext + MAG_BITS'(1)) : ext;
        end
    endfunction

    // Add a sign-extended sample to a sum, clamping at the signed sum limits.
    function automatic sum_t sat_add(input sum_t s, input logic [SAMPLE_BITS-1:0] v);
        logic [SUM_BITS:0] wide;
        begin
            wide = {s[SUM_BITS-1], s} + {{(SUM_BITS + 1 - SAMPLE_BITS){v[SAMPLE_BITS-1]}}, v};
            if (wide[SUM_BITS] != wide[SUM_BITS-1])
                sat_add = wide[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                         : {1'b0, {(SUM_BITS-1){1'b1}}};
            else
                sat_add = wide[SUM_BITS-1:0];
        end
    endfunction

    state_t                 state_reg, state_next;
    logic [STEP_BITS-1:0]   step_reg, step_next;
    logic [GATE_BITS-1:0]   gate_reg;
    sum_t                   sum_x_reg, sum_y_reg, sum_z_reg;
    count_t                 count_reg;
    logic                   acc_reg;
    logic                   out_valid_reg;

    logic                   in_fire;
    logic                   still;
    logic                   take;
    logic                   out_load;
    div_ctl_t               div_ctl;
    mean_t                  div_mean_x, div_mean_y, div_mean_z;

    // The gate register takes a write on any cycle; the host writes only while idle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gate_reg <= GATE_RESET;
        else if (cfg_valid && cfg_ready)
            gate_reg <= cfg_data;
    end

    // Stillness gate and the count limit decide whether a sample joins the sums.
    assign in_fire = in_valid && in_ready;
    assign still   = (magnitude(sample_x) <= {1'b0, gate_reg}) &&
                     (magnitude(sample_y) <= {1'b0, gate_reg}) &&
                     (magnitude(sample_z) <= {1'b0, gate_reg});
    assign take    = (command == CMD_SAMPLE) && still && (count_reg < MAX_SAMPLES);

    // Accumulators change only when an item is accepted, so the dividers see
    // a steady count and steady sums for the whole division.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            sum_z_reg <= '0;
            count_reg <= '0;
            acc_reg   <= 1'b0;
        end
        else if (in_fire)
        begin
            if (command == CMD_CLEAR)
            begin
                sum_x_reg <= '0;
                sum_y_reg <= '0;
                sum_z_reg <= '0;
                count_reg <= '0;
                acc_reg   <= 1'b0;
            end
            else if (take)
            begin
                sum_x_reg <= sat_add(sum_x_reg, sample_x);
                sum_y_reg <= sat_add(sum_y_reg, sample_y);
                sum_z_reg <= sat_add(sum_z_reg, sample_z);
                count_reg <= count_reg + COUNT_BITS'(1);
                acc_reg   <= 1'b1;
            end
            else
                acc_reg   <= 1'b0;
        end
    end

    // Sequencer: load the dividers, run one quotient bit per cycle, then hand
    // the means to the output register once it is free.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                    state_next = S_LOAD;
            end
            S_LOAD:
            begin
                step_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                step_next = step_reg + STEP_BITS'(1);
                if (step_reg == STEP_BITS'(SUM_BITS - 1))
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        div_ctl.load = 1'b0;
        div_ctl.step = 1'b0;
        out_load     = 1'b0;
        case (state_reg)
            S_IDLE: in_ready     = 1'b1;
            S_LOAD: div_ctl.load = 1'b1;
            S_DIV:  div_ctl.step = 1'b1;
            S_DONE: out_load     = !out_valid_reg || out_ready;
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // One serial divider per axis, all driven by the same sequencer.
    gtba_div u_div_x (
        .clk   (clk),
        .ctl   (div_ctl),
        .sum   (sum_x_reg),
        .count (count_reg),
        .mean  (div_mean_x)
    );

    gtba_div u_div_y (
        .clk   (clk),
        .ctl   (div_ctl),
        .sum   (sum_y_reg),
        .count (count_reg),
        .mean  (div_mean_y)
    );

    gtba_div u_div_z (
        .clk   (clk),
        .ctl   (div_ctl),
        .sum   (sum_z_reg),
        .count (count_reg),
        .mean  (div_mean_z)
    );

    // Output register: holds a finished item until the consumer takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            accepted     <= acc_reg;
            sample_total <= count_reg;
            mean_x       <= div_mean_x;
            mean_y       <= div_mean_y;
            mean_z       <= div_mean_z;
        end
    end

    assign out_valid = out_valid_reg;

    // A finished item always shows up on the output the cycle after loading.
    a_out_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid)
        else $error("output register did not present a loaded item");

    // A sample reported as added implies a nonzero count.
    a_acc_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && accepted) |-> (sample_total != '0))
        else $error("accepted item reported with an empty count");

    // A clear command empties the accumulator.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (command == CMD_CLEAR)) |=> (count_reg == '0))
        else $error("clear command left a nonzero count");

    // An accepted item is followed by the divider load, during which no new item is taken.
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (!in_ready && div_ctl.load))
        else $error("accepted item did not start a division");

endmodule

`default_nettype wire
